// ===== rtl/snsme_pkg.sv =====
package snsme_pkg;

  localparam int CAPACITY_DEF   = 64;
  localparam int COORD_BITS_DEF = 10;
  localparam int COST_BITS_DEF  = 16;

  localparam int OP_BITS     = 2;
  localparam int STATUS_BITS = 2;

  localparam logic [OP_BITS-1:0] OP_PUSH     = 2'd0;
  localparam logic [OP_BITS-1:0] OP_POP_MIN  = 2'd1;
  localparam logic [OP_BITS-1:0] OP_POP_XY   = 2'd2;
  localparam logic [OP_BITS-1:0] OP_READ_XY  = 2'd3;

  localparam logic [STATUS_BITS-1:0] ST_OK    = 2'd0;
  localparam logic [STATUS_BITS-1:0] ST_EMPTY = 2'd1;
  localparam logic [STATUS_BITS-1:0] ST_FULL  = 2'd2;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_FETCH,
    S_SHIFT,
    S_RESULT
  } state_t;

  // controller to datapath
  typedef struct packed {
    logic load_in;     // capture input word
    logic push_wr;     // write new entry at count
    logic scan_start;  // reset scan pointer and best
    logic scan_step;   // compare entry at scan pointer
    logic fetch;       // read selected entry to result
    logic shift_step;  // move one entry up
    logic cnt_dec;     // drop count
    logic res_load;    // build result word
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic [OP_BITS-1:0] op;
    logic               full;
    logic               empty;
    logic               scan_last;
    logic               found;
    logic               shift_done;
  } sts_t;

endpackage

// ===== rtl/snsme_datapath.sv =====
module snsme_datapath #(
  parameter int CAPACITY   = snsme_pkg::CAPACITY_DEF,
  parameter int COORD_BITS = snsme_pkg::COORD_BITS_DEF,
  parameter int COST_BITS  = snsme_pkg::COST_BITS_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  snsme_pkg::cmd_t                  cmd,
  output snsme_pkg::sts_t                  sts,
  input  logic [snsme_pkg::OP_BITS-1:0]    in_opcode,
  input  logic [COORD_BITS-1:0]            in_node_x,
  input  logic [COORD_BITS-1:0]            in_node_y,
  input  logic [COORD_BITS-1:0]            in_parent_x,
  input  logic [COORD_BITS-1:0]            in_parent_y,
  input  logic [COST_BITS-1:0]             in_total_cost,
  input  logic [COST_BITS-1:0]             in_path_cost,
  output logic [snsme_pkg::STATUS_BITS-1:0] res_status,
  output logic [COORD_BITS-1:0]            res_x,
  output logic [COORD_BITS-1:0]            res_y,
  output logic [COORD_BITS-1:0]            res_parent_x,
  output logic [COORD_BITS-1:0]            res_parent_y,
  output logic [COST_BITS-1:0]             res_total_cost,
  output logic [COST_BITS-1:0]             res_path_cost,
  output logic                             res_empty
);

  localparam int AW  = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CW  = $clog2(CAPACITY + 1);
  localparam int PTW = $clog2(CAPACITY + 2);  // scan pointer runs to count + 1
  localparam int PW  = 4 * COORD_BITS;
  localparam int KW  = 2 * COST_BITS;

  // entry stores: position word and cost word
  logic [PW-1:0] pos_mem [CAPACITY];
  logic [KW-1:0] cost_mem [CAPACITY];

  logic [CW-1:0]  count_r;
  logic [PTW-1:0] ptr_r;
  logic [AW-1:0]  best_r;
  logic           found_r;
  logic [COST_BITS-1:0] best_f_r;

  logic [snsme_pkg::OP_BITS-1:0] op_r;
  logic [COORD_BITS-1:0] x_r, y_r, px_r, py_r;
  logic [COST_BITS-1:0]  f_r, g_r;

  logic [PW-1:0] rd_pos_r;
  logic [KW-1:0] rd_cost_r;
  logic          rd_hit_r;

  logic [AW-1:0]  rd_addr;
  logic [PTW-1:0] ptr_inc;
  logic [PTW-1:0] cnt_ext;

  assign ptr_inc = ptr_r + PTW'(1);
  assign cnt_ext = PTW'(count_r);

  // read address: scan pointer, fetched entry or the one behind the hole
  always_comb begin
    rd_addr = ptr_r[AW-1:0];
    if (cmd.fetch) begin
      rd_addr = best_r;
    end else if (cmd.shift_step) begin
      rd_addr = ptr_inc[AW-1:0];
    end
  end

  // registered memory read
  always_ff @(posedge clk) begin
    rd_pos_r  <= pos_mem[rd_addr];
    rd_cost_r <= cost_mem[rd_addr];
  end

  // memory write: push at count, shift writes behind-entry into ptr
  always_ff @(posedge clk) begin
    if (cmd.push_wr) begin
      pos_mem[count_r[AW-1:0]]  <= {py_r, px_r, y_r, x_r};
      cost_mem[count_r[AW-1:0]] <= {g_r, f_r};
    end else if (cmd.shift_step && rd_hit_r) begin
      pos_mem[ptr_r[AW-1:0]]  <= rd_pos_r;
      cost_mem[ptr_r[AW-1:0]] <= rd_cost_r;
    end
  end

  // capture input word
  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      op_r <= in_opcode;
      x_r  <= in_node_x;
      y_r  <= in_node_y;
      px_r <= in_parent_x;
      py_r <= in_parent_y;
      f_r  <= in_total_cost;
      g_r  <= in_path_cost;
    end
  end

  logic [COST_BITS-1:0]  scan_f;
  logic [COORD_BITS-1:0] scan_x, scan_y;
  assign scan_f = rd_cost_r[COST_BITS-1:0];
  assign scan_x = rd_pos_r[COORD_BITS-1:0];
  assign scan_y = rd_pos_r[2*COORD_BITS-1:COORD_BITS];

  // scan: rd_hit_r marks that rd_*_r holds entry ptr_r-1 (registered read)
  // found_r also marks a push that was written
  logic [AW-1:0] prev_ptr_r;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r  <= '0;
      found_r  <= 1'b0;
      rd_hit_r <= 1'b0;
    end else begin
      rd_hit_r <= 1'b0;
      if (cmd.push_wr) begin
        count_r <= count_r + CW'(1);
        found_r <= 1'b1;
      end
      if (cmd.cnt_dec) begin
        count_r <= count_r - CW'(1);
      end
      if (cmd.scan_start) begin
        ptr_r    <= '0;
        found_r  <= 1'b0;
        best_r   <= '0;
        best_f_r <= '1;
      end
      if (cmd.scan_step) begin
        prev_ptr_r <= ptr_r[AW-1:0];
        rd_hit_r   <= (ptr_r < cnt_ext);
        ptr_r      <= ptr_inc;
        if (rd_hit_r) begin
          if (op_r == snsme_pkg::OP_POP_MIN) begin
            if (!found_r || scan_f < best_f_r) begin
              best_r   <= prev_ptr_r;
              best_f_r <= scan_f;
              found_r  <= 1'b1;
            end
          end else if (scan_x == x_r && scan_y == y_r) begin
            best_r  <= prev_ptr_r;
            found_r <= 1'b1;
          end
        end
      end
      if (cmd.fetch) begin
        ptr_r <= PTW'(best_r);
      end
      if (cmd.shift_step) begin
        // a step with rd_hit_r low loads behind-entry, the step after writes it
        if (rd_hit_r) begin
          ptr_r <= ptr_inc;
        end else begin
          rd_hit_r <= 1'b1;
        end
      end
    end
  end

  // fetched entry reaches rd_*_r through the registered memory read
  always_ff @(posedge clk) begin
    if (cmd.res_load) begin
      res_empty <= (count_r == '0);
      if (op_r == snsme_pkg::OP_PUSH) begin
        res_status <= found_r ? snsme_pkg::ST_OK : snsme_pkg::ST_FULL;
      end else begin
        res_status <= found_r ? snsme_pkg::ST_OK : snsme_pkg::ST_EMPTY;
      end
    end
  end

  logic [PW-1:0] hold_pos_r;
  logic [KW-1:0] hold_cost_r;
  logic          fetched_r;
  always_ff @(posedge clk) begin
    fetched_r <= cmd.fetch;
    if (cmd.scan_start) begin
      hold_pos_r  <= '0;
      hold_cost_r <= '0;
    end else if (fetched_r) begin
      hold_pos_r  <= rd_pos_r;
      hold_cost_r <= rd_cost_r;
    end
  end

  assign res_x          = hold_pos_r[COORD_BITS-1:0];
  assign res_y          = hold_pos_r[2*COORD_BITS-1:COORD_BITS];
  assign res_parent_x   = hold_pos_r[3*COORD_BITS-1:2*COORD_BITS];
  assign res_parent_y   = hold_pos_r[4*COORD_BITS-1:3*COORD_BITS];
  assign res_total_cost = hold_cost_r[COST_BITS-1:0];
  assign res_path_cost  = hold_cost_r[KW-1:COST_BITS];

  // scan is over the cycle after the last entry was compared
  assign sts.op         = op_r;
  assign sts.full       = (count_r == CW'(CAPACITY));
  assign sts.empty      = (count_r == '0);
  assign sts.scan_last  = !rd_hit_r && (ptr_r > cnt_ext);
  assign sts.found      = found_r;
  assign sts.shift_done = (ptr_inc >= cnt_ext);

endmodule

// ===== rtl/snsme_ctrl.sv =====
module snsme_ctrl (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  output logic            in_ready,
  output logic            out_valid,
  input  logic            out_ready,
  output snsme_pkg::cmd_t cmd,
  input  snsme_pkg::sts_t sts
);

  snsme_pkg::state_t state_r, state_nxt;
  logic              ovalid_r, ovalid_nxt;
  logic              fetch_wait_r;

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      snsme_pkg::S_IDLE: begin
        if (in_valid && !ovalid_r) begin
          state_nxt = snsme_pkg::S_SCAN;
        end
      end
      snsme_pkg::S_SCAN: begin
        if (sts.op == snsme_pkg::OP_PUSH) begin
          state_nxt = snsme_pkg::S_RESULT;
        end else if (sts.scan_last) begin
          state_nxt = sts.found ? snsme_pkg::S_FETCH : snsme_pkg::S_RESULT;
        end
      end
      snsme_pkg::S_FETCH: begin
        if (fetch_wait_r) begin
          state_nxt = (sts.op == snsme_pkg::OP_READ_XY) ? snsme_pkg::S_RESULT
                                                        : snsme_pkg::S_SHIFT;
        end
      end
      snsme_pkg::S_SHIFT: begin
        if (sts.shift_done) begin
          state_nxt = snsme_pkg::S_RESULT;
        end
      end
      snsme_pkg::S_RESULT: begin
        state_nxt = snsme_pkg::S_IDLE;
      end
      default: state_nxt = snsme_pkg::S_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    cmd = '0;
    ovalid_nxt = ovalid_r && !out_ready;
    case (state_r)
      snsme_pkg::S_IDLE: begin
        cmd.load_in    = in_valid && !ovalid_r;
        cmd.scan_start = in_valid && !ovalid_r;
      end
      snsme_pkg::S_SCAN: begin
        if (sts.op == snsme_pkg::OP_PUSH) begin
          cmd.push_wr = !sts.full;
        end else begin
          cmd.scan_step = !sts.scan_last;
          cmd.fetch     = sts.scan_last && sts.found;
        end
      end
      snsme_pkg::S_SHIFT: begin
        cmd.shift_step = !sts.shift_done;
        cmd.cnt_dec    = sts.shift_done;
      end
      snsme_pkg::S_RESULT: begin
        cmd.res_load = 1'b1;
        ovalid_nxt   = 1'b1;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= snsme_pkg::S_IDLE;
      ovalid_r     <= 1'b0;
      fetch_wait_r <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      ovalid_r     <= ovalid_nxt;
      fetch_wait_r <= (state_r == snsme_pkg::S_FETCH) && !fetch_wait_r;
    end
  end

  assign in_ready  = (state_r == snsme_pkg::S_IDLE) && !ovalid_r;
  assign out_valid = ovalid_r;

endmodule

// ===== rtl/search_node_set_min_extract.sv =====
// Search node set: bounded open set for a grid path search, push order kept.
// Input channel in_valid/in_ready carries one operation word: in_opcode
// (push, pop least total cost, pop by coordinates, read by coordinates) and
// the node fields. Result channel out_valid/out_ready carries one word per
// operation: status, node fields (zero unless a node is returned), set_empty.
// Push appends the node unless the set is full. Pop or read scan
// all stored entries through one memory read port, one entry a cycle.
// A pop then closes the gap by moving each later entry up: each one is
// read and then written one place up.
// One operation is in flight at a time; a new word is taken only once the
// previous result has been taken. If the receiver stalls, the result word
// holds on the out_ ports. Reset (rst_n low, synchronous) empties the set;
// entry storage is not cleared, entries past the count are never used.
module search_node_set_min_extract #(
  parameter int CAPACITY   = snsme_pkg::CAPACITY_DEF,
  parameter int COORD_BITS = snsme_pkg::COORD_BITS_DEF,
  parameter int COST_BITS  = snsme_pkg::COST_BITS_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic [snsme_pkg::OP_BITS-1:0]     in_opcode,
  input  logic [COORD_BITS-1:0]             in_node_x,
  input  logic [COORD_BITS-1:0]             in_node_y,
  input  logic [COORD_BITS-1:0]             in_parent_x,
  input  logic [COORD_BITS-1:0]             in_parent_y,
  input  logic [COST_BITS-1:0]              in_total_cost,
  input  logic [COST_BITS-1:0]              in_path_cost,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic [snsme_pkg::STATUS_BITS-1:0] out_status,
  output logic [COORD_BITS-1:0]             out_x,
  output logic [COORD_BITS-1:0]             out_y,
  output logic [COORD_BITS-1:0]             out_parent_x,
  output logic [COORD_BITS-1:0]             out_parent_y,
  output logic [COST_BITS-1:0]              out_total_cost,
  output logic [COST_BITS-1:0]              out_path_cost,
  output logic                              out_set_empty
);

  snsme_pkg::cmd_t cmd;
  snsme_pkg::sts_t sts;

  snsme_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .cmd       (cmd),
    .sts       (sts)
  );

  snsme_datapath #(
    .CAPACITY   (CAPACITY),
    .COORD_BITS (COORD_BITS),
    .COST_BITS  (COST_BITS)
  ) u_dp (
    .clk            (clk),
    .rst_n          (rst_n),
    .cmd            (cmd),
    .sts            (sts),
    .in_opcode      (in_opcode),
    .in_node_x      (in_node_x),
    .in_node_y      (in_node_y),
    .in_parent_x    (in_parent_x),
    .in_parent_y    (in_parent_y),
    .in_total_cost  (in_total_cost),
    .in_path_cost   (in_path_cost),
    .res_status     (out_status),
    .res_x          (out_x),
    .res_y          (out_y),
    .res_parent_x   (out_parent_x),
    .res_parent_y   (out_parent_y),
    .res_total_cost (out_total_cost),
    .res_path_cost  (out_path_cost),
    .res_empty      (out_set_empty)
  );

endmodule
